[src/psp_pkg.sv]
`timescale 1ns / 1ps

package psp_pkg;

	typedef enum logic [1:0] {
		KIND_PROGRAM = 2'd0,
		KIND_NETWORK = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	localparam logic [10:0] MAX_PROGRAMS  = 11'd1024;
	localparam logic [12:0] POS_MAX       = 13'h1fff;
	localparam logic [3:0]  HDR_COUNT     = 4'd8;
	localparam logic [3:0]  LEN_HI_MASK   = 4'hf;
	localparam logic [4:0]  PID_HI_MASK   = 5'h1f;
	localparam logic [13:0] TOTAL_EXTRA   = 14'd3;
	localparam logic [12:0] FIRST_ENTRY_END = 13'd11;
	localparam logic [12:0] MIN_END_POS   = 13'd2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       section_start;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] prog_num;
		logic [12:0] pid;
		logic [7:0]  tbl_id;
		logic [10:0] program_count;
		logic [11:0] sect_len;
		logic [15:0] stream_id;
		logic [4:0]  version;
		logic        current_next;
		logic [7:0]  section_index;
		logic [7:0]  last_section_index;
		logic [31:0] crc_word;
	} result_t;

endpackage

[src/psp_in_stage.sv]
`timescale 1ns / 1ps

module psp_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  psp_pkg::in_item_t in_item,
	input  logic             advance,
	output logic             item_valid_s1,
	output psp_pkg::in_item_t item_s1
);
	import psp_pkg::*;

	logic take;

	assign in_stall = item_valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

[src/psp_decode.sv]
`timescale 1ns / 1ps

module psp_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              item_valid_s1,
	input  psp_pkg::in_item_t item_s1,
	output logic              has_result,
	output psp_pkg::result_t  result
);
	import psp_pkg::*;

	logic             in_section_q;
	logic [12:0]      pos_q;
	logic [7:0][7:0]  hdr_q;
	logic [23:0]      entry_q;
	logic [31:0]      tail_q;
	logic [10:0]      count_q;

	logic             eff_in;
	logic [12:0]      eff_pos;
	logic [7:0][7:0]  eff_hdr;
	logic [7:0][7:0]  hdr_n;
	logic [23:0]      eff_entry;
	logic [31:0]      eff_tail;
	logic [31:0]      tail_n;
	logic [10:0]      eff_count;
	logic [11:0]      len;
	logic [13:0]      total;
	logic [13:0]      pos_next;
	logic             is_entry;
	logic             is_summary;
	logic [15:0]      pn;
	logic             do_step;

	always_comb begin
		if (item_s1.section_start) begin
			eff_in    = 1'b1;
			eff_pos   = '0;
			eff_hdr   = '0;
			eff_entry = '0;
			eff_tail  = '0;
			eff_count = '0;
		end else begin
			eff_in    = in_section_q;
			eff_pos   = pos_q;
			eff_hdr   = hdr_q;
			eff_entry = entry_q;
			eff_tail  = tail_q;
			eff_count = count_q;
		end

		hdr_n = eff_hdr;
		for (int k = 0; k < 8; k++) begin
			if ({1'b0, eff_pos} < {10'd0, HDR_COUNT} && eff_pos[2:0] == 3'(k)) begin
				hdr_n[k] = item_s1.byte_value;
			end
		end
		tail_n = {eff_tail[23:0], item_s1.byte_value};

		len      = {hdr_n[1][3:0] & LEN_HI_MASK, hdr_n[2]};
		total    = {2'b00, len} + TOTAL_EXTRA;
		pos_next = {1'b0, eff_pos} + 14'd1;
		pn       = eff_entry[23:8];

		is_entry   = eff_in && eff_pos >= FIRST_ENTRY_END && eff_pos[1:0] == 2'b11 &&
			pos_next < total;
		is_summary = eff_in && eff_pos >= MIN_END_POS && pos_next == total;
		has_result = is_entry || is_summary;

		result = '0;
		if (is_summary) begin
			result.kind               = KIND_SUMMARY;
			result.tbl_id             = hdr_n[0];
			result.program_count      = eff_count;
			result.sect_len           = len;
			result.stream_id          = {hdr_n[3], hdr_n[4]};
			result.version            = hdr_n[5][5:1];
			result.current_next       = hdr_n[5][0];
			result.section_index      = hdr_n[6];
			result.last_section_index = hdr_n[7];
			result.crc_word           = tail_n;
		end else if (is_entry) begin
			result.kind = (pn == 16'd0) ? KIND_NETWORK : KIND_PROGRAM;
			result.prog_num = pn;
			result.pid = {eff_entry[4:0] & PID_HI_MASK, item_s1.byte_value};
		end
	end

	assign do_step = advance && item_valid_s1 && eff_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_section_q <= 1'b0;
			pos_q        <= '0;
			hdr_q        <= '0;
			entry_q      <= '0;
			tail_q       <= '0;
			count_q      <= '0;
		end else if (do_step) begin
			in_section_q <= !is_summary;
			pos_q        <= (eff_pos < POS_MAX) ? pos_next[12:0] : eff_pos;
			hdr_q        <= hdr_n;
			entry_q      <= {eff_entry[15:0], item_s1.byte_value};
			tail_q       <= tail_n;
			if (is_entry && pn != 16'd0 && eff_count < MAX_PROGRAMS) begin
				count_q <= eff_count + 11'd1;
			end else begin
				count_q <= eff_count;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_PROGRAMS)
		else $error("program count beyond limit");

	a_summary_closes: assert property (@(posedge clk) disable iff (!arst_n)
		do_step && is_summary |=> !in_section_q)
		else $error("section still open after summary");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!in_section_q && !item_s1.section_start |-> !has_result)
		else $error("result outside a section");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_entry && is_summary))
		else $error("entry and summary in one transaction");

endmodule

[src/pat_section_parser_unit.sv]
`timescale 1ns / 1ps
// path: an accepted byte is registered in the input stage, and its result is then registered in the output stage
// throughput: one byte per cycle, set by the single decode pass between input
// and result registers; a stalled result holds back the input stage
// reset: arst_n clears both valid flags and all section state (no open section)
// payload registers are not reset

module pat_section_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        section_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] prog_num,
	output logic [12:0] pid,
	output logic [7:0]  tbl_id,
	output logic [10:0] program_count,
	output logic [11:0] sect_len,
	output logic [15:0] stream_id,
	output logic [4:0]  version,
	output logic        current_next,
	output logic [7:0]  section_index,
	output logic [7:0]  last_section_index,
	output logic [31:0] crc_word
);
	import psp_pkg::*;

	in_item_t in_item;
	in_item_t item_s1;
	logic     item_valid_s1;
	logic     advance;
	logic     has_result;
	result_t  result;
	logic     out_valid_s2;
	result_t  result_s2;

	assign in_item.byte_value    = byte_value;
	assign in_item.section_start = section_start;

	assign advance = item_valid_s1 && (!out_valid_s2 || !out_stall);

	psp_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	psp_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.has_result    (has_result),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= has_result;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_s2 <= result;
		end
	end

	assign out_valid          = out_valid_s2;
	assign kind               = result_s2.kind;
	assign prog_num           = result_s2.prog_num;
	assign pid                = result_s2.pid;
	assign tbl_id             = result_s2.tbl_id;
	assign program_count      = result_s2.program_count;
	assign sect_len           = result_s2.sect_len;
	assign stream_id          = result_s2.stream_id;
	assign version            = result_s2.version;
	assign current_next       = result_s2.current_next;
	assign section_index      = result_s2.section_index;
	assign last_section_index = result_s2.last_section_index;
	assign crc_word           = result_s2.crc_word;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_stall |-> !advance)
		else $error("pending result overwritten");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> item_valid_s1 && out_valid_s2 && out_stall)
		else $error("input stalled without cause");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result |=> out_valid_s2)
		else $error("result dropped");

endmodule
